// ===== src/ccd_pkg.sv =====
// Shared types, constants and lookup functions for the cheat code decoder.
// No dependencies; the lane, merge, decrypt stage, top level and checker import this package.
package ccd_pkg;

    localparam int CHARS = 10;

    localparam logic [3:0] LEN_GG_SHORT = 4'd6;
    localparam logic [3:0] LEN_RAW_SHORT = 4'd7;
    localparam logic [3:0] LEN_GG_LONG = 4'd8;
    localparam logic [3:0] LEN_RAW_LONG = 4'd10;

    localparam logic [1:0] FMT_GG = 2'd0;
    localparam logic [1:0] FMT_PAR = 2'd1;
    localparam logic [1:0] FMT_RAW = 2'd2;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [31:0] PAR_KEY = 32'h7E5E_E93A;
    localparam logic [31:0] PAR_XV = 32'h5C18_4B91;

    localparam logic [7:0] GG_LETTERS [16] = '{
        "A", "P", "Z", "L", "G", "I", "T", "Y",
        "E", "O", "X", "U", "K", "S", "V", "N"
    };

    localparam logic [4:0] GG_ADDR_MAP [15] = '{
        5'd14, 5'd13, 5'd12, 5'd19, 5'd22, 5'd21, 5'd20, 5'd7,
        5'd10, 5'd9, 5'd8, 5'd15, 5'd18, 5'd17, 5'd16
    };
    localparam logic [4:0] GG_VAL_MAP [8] = '{
        5'd3, 5'd6, 5'd5, 5'd4, 5'd23, 5'd2, 5'd1, 5'd0
    };
    localparam logic [4:0] GG_CMP_MAP [8] = '{
        5'd27, 5'd30, 5'd29, 5'd28, 5'd23, 5'd26, 5'd25, 5'd24
    };
    localparam logic [4:0] GG_VAL_LONG_BIT = 5'd31;
    localparam int GG_VAL_SWAP = 4;

    localparam logic [4:0] PAR_SCATTER [31] = '{
        5'd3, 5'd13, 5'd14, 5'd1, 5'd6, 5'd9, 5'd5, 5'd0,
        5'd12, 5'd7, 5'd2, 5'd8, 5'd10, 5'd11, 5'd4,
        5'd19, 5'd21, 5'd23, 5'd22, 5'd20, 5'd17, 5'd16, 5'd18,
        5'd29, 5'd31, 5'd24, 5'd26, 5'd25, 5'd30, 5'd27, 5'd28
    };

    typedef struct packed {
        logic       gg_ok;
        logic [3:0] gg_nib;
        logic       hex_ok;
        logic [3:0] hex_nib;
        logic       colon;
    } lane_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  code_format;
        logic [15:0] patch_address;
        logic [7:0]  patch_value;
        logic [7:0]  compare_value;
        logic        compare_en;
    } patch_t;

    typedef struct packed {
        patch_t      dec;
        logic        par;
        logic [31:0] key;
        logic [31:0] enc;
        logic [31:0] res;
    } pipe_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= "a" && c <= "z") begin
            u = c - 8'd32;
        end
        return u;
    endfunction

    function automatic logic [4:0] gg_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [4:0] r;
        u = upcase(c);
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (GG_LETTERS[i] == u) begin
                r = {1'b1, 4'(i)};
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] hex_lookup(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        logic [4:0] r;
        u = upcase(c);
        d = '0;
        r = '0;
        if (u >= "0" && u <= "9") begin
            d = u - 8'h30;
            r = {1'b1, d[3:0]};
        end else if (u >= "A" && u <= "F") begin
            d = u - 8'h37;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== src/ccd_code_if.sv =====
// Input channel of the cheat code decoder: one code word per handshake.
// Depends on nothing.
interface ccd_code_if;
    logic       valid;
    logic       ready;
    logic [3:0] char_count;
    logic [7:0] char_0;
    logic [7:0] char_1;
    logic [7:0] char_2;
    logic [7:0] char_3;
    logic [7:0] char_4;
    logic [7:0] char_5;
    logic [7:0] char_6;
    logic [7:0] char_7;
    logic [7:0] char_8;
    logic [7:0] char_9;

    modport source (
        output valid, char_count, char_0, char_1, char_2, char_3, char_4,
               char_5, char_6, char_7, char_8, char_9,
        input  ready
    );
    modport sink (
        input  valid, char_count, char_0, char_1, char_2, char_3, char_4,
               char_5, char_6, char_7, char_8, char_9,
        output ready
    );
endinterface

// ===== src/ccd_patch_if.sv =====
// Output channel of the cheat code decoder: one patch word per handshake.
// Depends on nothing.
interface ccd_patch_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  code_format;
    logic [15:0] patch_address;
    logic [7:0]  patch_value;
    logic [7:0]  compare_value;
    logic        compare_en;

    modport source (
        output valid, status, code_format, patch_address, patch_value,
               compare_value, compare_en,
        input  ready
    );
    modport sink (
        input  valid, status, code_format, patch_address, patch_value,
               compare_value, compare_en,
        output ready
    );
endinterface

// ===== src/ccd_char_lane.sv =====
// One character lane: classifies a code character as letter, hex digit or colon.
// Depends on ccd_pkg.
module ccd_char_lane
    import ccd_pkg::*;
(
    input  logic [7:0] ch,
    output lane_t      lane
);

    logic [4:0] gg;
    logic [4:0] hx;

    always_comb
    begin
        gg = gg_lookup(ch);
        hx = hex_lookup(ch);
        lane.gg_ok = gg[4];
        lane.gg_nib = gg[3:0];
        lane.hex_ok = hx[4];
        lane.hex_nib = hx[3:0];
        lane.colon = (ch == CHAR_COLON);
    end

endmodule

// ===== src/ccd_merge.sv =====
// Merge stage: combines the lane results into a decoded patch or a
// decrypt job for the Action Replay path. Depends on ccd_pkg.
module ccd_merge
    import ccd_pkg::*;
(
    input  logic [3:0] char_count,
    input  lane_t      lanes [CHARS],
    output pipe_t      q
);

    logic        is_gg6;
    logic        is_gg8;
    logic        is_raw7;
    logic        is_raw10;
    logic        gg_good;
    logic        hex8_good;
    logic        raw_good;
    logic [31:0] word;
    logic [31:0] enc;
    logic [14:0] gg_addr;
    logic [7:0]  gg_val;
    logic [7:0]  gg_cmp;
    logic [4:0]  vidx;

    always_comb
    begin
        is_gg6 = (char_count == LEN_GG_SHORT);
        is_gg8 = (char_count == LEN_GG_LONG);
        is_raw7 = (char_count == LEN_RAW_SHORT);
        is_raw10 = (char_count == LEN_RAW_LONG);

        word = '0;
        gg_good = 1'b1;
        hex8_good = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (i < 6 || is_gg8) begin
                word[4*i +: 4] = lanes[i].gg_nib;
                gg_good = gg_good & lanes[i].gg_ok;
            end
            hex8_good = hex8_good & lanes[i].hex_ok;
            enc[31-4*i -: 4] = lanes[i].hex_nib;
        end

        for (int k = 0; k < 15; k++) begin
            gg_addr[14-k] = word[GG_ADDR_MAP[k]];
        end
        for (int k = 0; k < 8; k++) begin
            vidx = (k == GG_VAL_SWAP && is_gg8) ? GG_VAL_LONG_BIT : GG_VAL_MAP[k];
            gg_val[7-k] = word[vidx];
            gg_cmp[7-k] = word[GG_CMP_MAP[k]];
        end

        raw_good = lanes[4].colon
            && lanes[0].hex_ok && lanes[1].hex_ok && lanes[2].hex_ok && lanes[3].hex_ok
            && lanes[5].hex_ok && lanes[6].hex_ok
            && (is_raw7 || (lanes[7].colon && lanes[8].hex_ok && lanes[9].hex_ok));

        q.dec = '0;
        q.dec.status = STATUS_BAD;
        q.par = 1'b0;
        q.key = PAR_KEY;
        q.enc = {1'b0, enc[31:1]};
        q.res = '0;

        if ((is_gg6 || is_gg8) && gg_good) begin
            q.dec.status = STATUS_OK;
            q.dec.code_format = FMT_GG;
            q.dec.patch_address = {1'b1, gg_addr};
            q.dec.patch_value = gg_val;
            q.dec.compare_value = is_gg8 ? gg_cmp : 8'd0;
            q.dec.compare_en = is_gg8;
        end else if (is_gg8 && hex8_good) begin
            q.par = 1'b1;
        end else if ((is_raw7 || is_raw10) && raw_good) begin
            q.dec.status = STATUS_OK;
            q.dec.code_format = FMT_RAW;
            q.dec.patch_address = {lanes[0].hex_nib, lanes[1].hex_nib,
                                   lanes[2].hex_nib, lanes[3].hex_nib};
            q.dec.patch_value = {lanes[5].hex_nib, lanes[6].hex_nib};
            q.dec.compare_value = is_raw10 ? {lanes[8].hex_nib, lanes[9].hex_nib} : 8'd0;
            q.dec.compare_en = is_raw10;
        end
    end

endmodule

// ===== src/ccd_par_stage.sv =====
// A slice of the Action Replay decrypt chain: runs STEP_CNT keyed
// shift/xor steps from step STEP_HI downward. Depends on ccd_pkg.
module ccd_par_stage
    import ccd_pkg::*;
#(
    parameter int STEP_HI = 30,
    parameter int STEP_CNT = 8
)
(
    input  pipe_t d,
    output pipe_t q
);

    logic [31:0] key;
    logic [31:0] enc;
    logic [31:0] res;

    always_comb
    begin
        key = d.key;
        enc = d.enc;
        res = d.res;
        for (int j = 0; j < STEP_CNT; j++) begin
            if (key[30] ^ enc[30]) begin
                res[PAR_SCATTER[STEP_HI-j]] = 1'b1;
                key = key ^ PAR_XV;
            end
            enc = {enc[30:0], 1'b0};
            key = {key[30:0], 1'b0};
        end
        q = d;
        q.key = key;
        q.enc = enc;
        q.res = res;
    end

endmodule

// ===== src/cheat_code_decoder.sv =====
// Cheat code decoder top level: lanes, merge stage and decrypt pipeline.
// Depends on ccd_pkg, ccd_code_if, ccd_patch_if, ccd_char_lane, ccd_merge, ccd_par_stage.

// Decodes one Game Genie, Pro Action Replay or raw hex cheat code per clock
// into a bus patch while the output is not stalled. Ten character lanes
// classify the code text in parallel and a merge stage assembles the result;
// the 31-step Action Replay decrypt chain is split across four stages of at
// most eight steps. Every format passes the stage registers and the output
// register, and a new code is taken every cycle while results are drained.
// Output backpressure holds the pipeline, which can keep five codes in flight.
module cheat_code_decoder
    import ccd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ccd_code_if.sink           code_in,
    ccd_patch_if.source        patch_out
);

    localparam int STAGES = 4;

    logic [7:0] chars [CHARS];
    lane_t      lanes [CHARS];
    pipe_t      merged;
    pipe_t      pipe_reg [STAGES];
    pipe_t      stage_out [STAGES];
    patch_t     out_reg;
    patch_t     out_next;
    logic [STAGES:0] vld_reg;
    logic [STAGES:0] vld_next;
    logic [STAGES:0] rdy;

    assign chars[0] = code_in.char_0;
    assign chars[1] = code_in.char_1;
    assign chars[2] = code_in.char_2;
    assign chars[3] = code_in.char_3;
    assign chars[4] = code_in.char_4;
    assign chars[5] = code_in.char_5;
    assign chars[6] = code_in.char_6;
    assign chars[7] = code_in.char_7;
    assign chars[8] = code_in.char_8;
    assign chars[9] = code_in.char_9;

    for (genvar g = 0; g < CHARS; g++) begin : g_lane
        ccd_char_lane u_lane (
            .ch   (chars[g]),
            .lane (lanes[g])
        );
    end

    ccd_merge u_merge (
        .char_count  (code_in.char_count),
        .lanes       (lanes),
        .q           (merged)
    );

    ccd_par_stage #(.STEP_HI(30), .STEP_CNT(8)) u_par0 (.d(pipe_reg[0]), .q(stage_out[0]));
    ccd_par_stage #(.STEP_HI(22), .STEP_CNT(8)) u_par1 (.d(pipe_reg[1]), .q(stage_out[1]));
    ccd_par_stage #(.STEP_HI(14), .STEP_CNT(8)) u_par2 (.d(pipe_reg[2]), .q(stage_out[2]));
    ccd_par_stage #(.STEP_HI(6), .STEP_CNT(7)) u_par3 (.d(pipe_reg[3]), .q(stage_out[3]));

    always_comb
    begin
        rdy[STAGES] = !vld_reg[STAGES] || patch_out.ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? code_in.valid : vld_reg[0];
        for (int k = 1; k <= STAGES; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_comb
    begin
        out_next = stage_out[STAGES-1].dec;
        if (stage_out[STAGES-1].par) begin
            out_next.status = STATUS_OK;
            out_next.code_format = FMT_PAR;
            out_next.patch_address = {1'b1, stage_out[STAGES-1].res[14:0]};
            out_next.patch_value = stage_out[STAGES-1].res[31:24];
            out_next.compare_value = stage_out[STAGES-1].res[23:16];
            out_next.compare_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0]) begin
            pipe_reg[0] <= merged;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
                pipe_reg[k] <= stage_out[k-1];
            end
        end
        if (rdy[STAGES]) begin
            out_reg <= out_next;
        end
    end

    assign code_in.ready = rdy[0];
    assign patch_out.valid = vld_reg[STAGES];
    assign patch_out.status = out_reg.status;
    assign patch_out.code_format = out_reg.code_format;
    assign patch_out.patch_address = out_reg.patch_address;
    assign patch_out.patch_value = out_reg.patch_value;
    assign patch_out.compare_value = out_reg.compare_value;
    assign patch_out.compare_en = out_reg.compare_en;

endmodule

// ===== src/ccd_checker.sv =====
// Port-level checks for the cheat code decoder, bound to the top level.
// Depends on ccd_pkg and cheat_code_decoder.
module ccd_checker
    import ccd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        status,
    input logic [1:0]  code_format,
    input logic [15:0] patch_address,
    input logic [7:0]  patch_value,
    input logic [7:0]  compare_value,
    input logic        compare_en
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(code_format)
            && $stable(patch_address) && $stable(patch_value)
            && $stable(compare_value) && $stable(compare_en))
        else $error("stalled output word changed");

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_BAD |-> code_format == FMT_GG
            && patch_address == 16'd0 && patch_value == 8'd0
            && compare_value == 8'd0 && !compare_en)
        else $error("invalid code word carries nonzero fields");

    a_par_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK && code_format == FMT_PAR
            |-> compare_en && patch_address[15])
        else $error("action replay word without compare or high address bit");

endmodule

bind cheat_code_decoder ccd_checker u_ccd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (code_in.ready),
    .out_valid     (patch_out.valid),
    .out_ready     (patch_out.ready),
    .status        (patch_out.status),
    .code_format   (patch_out.code_format),
    .patch_address (patch_out.patch_address),
    .patch_value   (patch_out.patch_value),
    .compare_value (patch_out.compare_value),
    .compare_en    (patch_out.compare_en)
);
